// ===== design/pdc_pkg.sv =====
`default_nettype none
package pdc_pkg;

  localparam int unsigned COUNT_BITS   = 18;
  localparam int unsigned HDR_SIZE     = 24;
  localparam int unsigned HDR_CRC_SPAN = 16;
  localparam int unsigned PKT_CRC_SPAN = 20;
  localparam int unsigned HDR_IDX_W    = $clog2(HDR_SIZE);
  localparam int unsigned LEN_SUM_W    = 18;

  localparam logic [COUNT_BITS-1:0] CNT_MAX  = '1;
  localparam logic [31:0]           CRC_POLY = 32'hEDB8_8320;
  localparam logic [31:0]           CRC_INIT = 32'hFFFF_FFFF;

  // APB register map, word aligned
  localparam int unsigned PADDR_W = 4;
  typedef enum logic [1:0] {
    REG_START_MARKER   = 2'd0,
    REG_FORMAT_VERSION = 2'd1,
    REG_FORMAT_IDENT   = 2'd2
  } pdc_reg_e;

  typedef enum logic [1:0] {
    RGN_HEADER  = 2'd0,
    RGN_PAYLOAD = 2'd1,
    RGN_OOB     = 2'd2
  } pdc_region_e;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_IDENT   = 3'd1,
    ST_HDR_LEN = 3'd2,
    ST_TOT_LEN = 3'd3,
    ST_HDR_CRC = 3'd4,
    ST_PKT_CRC = 3'd5
  } pdc_status_e;

  typedef struct packed {
    logic [7:0]  start_marker;
    logic [7:0]  format_version;
    logic [15:0] format_ident;
  } pdc_cfg_t;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       is_final;
  } pdc_item_t;

  typedef struct packed {
    logic [7:0]  out_byte;
    pdc_region_e region;
    logic        verdict_valid;
    pdc_status_e status;
  } pdc_result_t;

  // Reflected CRC-32, one byte
  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage
`default_nettype wire

// ===== design/pdc_in_if.sv =====
`default_nettype none
interface pdc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       is_final;

  modport source (output valid, output in_byte, output is_final, input ready);
  modport sink (input valid, input in_byte, input is_final, output ready);
endinterface
`default_nettype wire

// ===== design/pdc_out_if.sv =====
`default_nettype none
interface pdc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic [1:0] region;
  logic       verdict_valid;
  logic [2:0] status;

  modport source (output valid, output out_byte, output region, output verdict_valid,
                  output status, input ready);
  modport sink (input valid, input out_byte, input region, input verdict_valid,
                input status, output ready);
endinterface
`default_nettype wire

// ===== design/pdc_cfg_regs.sv =====
`default_nettype none
module pdc_cfg_regs (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [pdc_pkg::PADDR_W-1:0]  paddr,
  input  wire logic [31:0]                  pwdata,
  output logic      [31:0]                  prdata,
  output logic                              pready,
  output pdc_pkg::pdc_cfg_t                 cfg_o
);

  pdc_pkg::pdc_cfg_t cfg_q;
  logic              wr_en;
  logic [1:0]        reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_sel = paddr[3:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (wr_en) begin
      case (reg_sel)
        pdc_pkg::REG_START_MARKER:   cfg_q.start_marker   <= pwdata[7:0];
        pdc_pkg::REG_FORMAT_VERSION: cfg_q.format_version <= pwdata[7:0];
        pdc_pkg::REG_FORMAT_IDENT:   cfg_q.format_ident   <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      pdc_pkg::REG_START_MARKER:   prdata = {24'd0, cfg_q.start_marker};
      pdc_pkg::REG_FORMAT_VERSION: prdata = {24'd0, cfg_q.format_version};
      pdc_pkg::REG_FORMAT_IDENT:   prdata = {16'd0, cfg_q.format_ident};
      default:                     prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule
`default_nettype wire

// ===== design/pdc_parser.sv =====
`default_nettype none
module pdc_parser (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  advance_i,
  input  wire pdc_pkg::pdc_item_t    item_i,
  input  wire pdc_pkg::pdc_cfg_t     cfg_i,
  output pdc_pkg::pdc_result_t       res_o
);

  logic [pdc_pkg::COUNT_BITS-1:0] idx_q, idx_d, count;
  logic [31:0]                    hcrc_q, hcrc_d, pcrc_q, pcrc_d;
  logic [7:0]                     hdr_q [pdc_pkg::HDR_SIZE];
  logic [7:0]                     hv [pdc_pkg::HDR_SIZE];
  logic                           in_hdr;
  logic [15:0]                    f_ident, f_hlen, f_plen, f_olen;
  logic [31:0]                    f_hcrc, f_pcrc;
  logic [pdc_pkg::LEN_SUM_W-1:0]  len_sum;
  logic [pdc_pkg::COUNT_BITS-1:0] body_off;
  pdc_pkg::pdc_status_e           status;
  pdc_pkg::pdc_region_e           region;

  assign in_hdr = idx_q < pdc_pkg::COUNT_BITS'(pdc_pkg::HDR_SIZE);

  // Header view with the current byte merged in
  always_comb begin
    for (int i = 0; i < pdc_pkg::HDR_SIZE; i++) begin
      hv[i] = (idx_q == pdc_pkg::COUNT_BITS'(i)) ? item_i.in_byte : hdr_q[i];
    end
  end

  assign f_ident = {hv[3], hv[2]};
  assign f_hlen  = {hv[5], hv[4]};
  assign f_plen  = {hv[7], hv[6]};
  assign f_olen  = {hv[9], hv[8]};
  assign f_hcrc  = {hv[19], hv[18], hv[17], hv[16]};
  assign f_pcrc  = {hv[23], hv[22], hv[21], hv[20]};
  assign len_sum = pdc_pkg::LEN_SUM_W'(f_hlen) + pdc_pkg::LEN_SUM_W'(f_plen)
                 + pdc_pkg::LEN_SUM_W'(f_olen);

  always_comb begin
    hcrc_d = hcrc_q;
    pcrc_d = pcrc_q;
    if (idx_q < pdc_pkg::COUNT_BITS'(pdc_pkg::HDR_CRC_SPAN)) begin
      hcrc_d = pdc_pkg::crc_byte(hcrc_q, item_i.in_byte);
    end
    if (idx_q < pdc_pkg::COUNT_BITS'(pdc_pkg::PKT_CRC_SPAN) || !in_hdr) begin
      pcrc_d = pdc_pkg::crc_byte(pcrc_q, item_i.in_byte);
    end
  end

  assign count    = (idx_q != pdc_pkg::CNT_MAX) ? idx_q + 1'b1 : pdc_pkg::CNT_MAX;
  assign idx_d    = item_i.is_final ? '0 : count;
  assign body_off = idx_q - pdc_pkg::COUNT_BITS'(pdc_pkg::HDR_SIZE);

  always_comb begin
    if (in_hdr) begin
      region = pdc_pkg::RGN_HEADER;
    end else if (body_off < pdc_pkg::COUNT_BITS'(f_plen)) begin
      region = pdc_pkg::RGN_PAYLOAD;
    end else begin
      region = pdc_pkg::RGN_OOB;
    end
  end

  // First failing check wins
  always_comb begin
    if (count < pdc_pkg::COUNT_BITS'(pdc_pkg::HDR_SIZE) || hv[0] != cfg_i.start_marker
        || hv[1] != cfg_i.format_version || f_ident != cfg_i.format_ident) begin
      status = pdc_pkg::ST_IDENT;
    end else if (f_hlen != 16'(pdc_pkg::HDR_SIZE)) begin
      status = pdc_pkg::ST_HDR_LEN;
    end else if (pdc_pkg::COUNT_BITS'(len_sum) != count) begin
      status = pdc_pkg::ST_TOT_LEN;
    end else if (~hcrc_q != f_hcrc) begin
      status = pdc_pkg::ST_HDR_CRC;
    end else if (~pcrc_d != f_pcrc) begin
      status = pdc_pkg::ST_PKT_CRC;
    end else begin
      status = pdc_pkg::ST_OK;
    end
  end

  assign res_o.out_byte      = item_i.in_byte;
  assign res_o.region        = region;
  assign res_o.verdict_valid = item_i.is_final;
  assign res_o.status        = item_i.is_final ? status : pdc_pkg::ST_OK;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q  <= '0;
      hcrc_q <= pdc_pkg::CRC_INIT;
      pcrc_q <= pdc_pkg::CRC_INIT;
    end else if (advance_i) begin
      idx_q  <= idx_d;
      hcrc_q <= item_i.is_final ? pdc_pkg::CRC_INIT : hcrc_d;
      pcrc_q <= item_i.is_final ? pdc_pkg::CRC_INIT : pcrc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_i && in_hdr) begin
      hdr_q[idx_q[pdc_pkg::HDR_IDX_W-1:0]] <= item_i.in_byte;
    end
  end

  a_final_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance_i && item_i.is_final |=> idx_q == '0 && hcrc_q == pdc_pkg::CRC_INIT
      && pcrc_q == pdc_pkg::CRC_INIT)
    else $error("parser state not restarted after final byte");

  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance_i && !item_i.is_final && idx_q != pdc_pkg::CNT_MAX
      |=> idx_q == $past(idx_q) + 1'b1)
    else $error("byte count did not advance by one");

  a_idle_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !advance_i |=> $stable(idx_q) && $stable(hcrc_q) && $stable(pcrc_q))
    else $error("parser state moved without an item");

  a_hdr_crc_frozen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance_i && !item_i.is_final
      && idx_q >= pdc_pkg::COUNT_BITS'(pdc_pkg::HDR_CRC_SPAN) |=> $stable(hcrc_q))
    else $error("header CRC updated past its span");

endmodule
`default_nettype wire

// ===== design/packet_deframer_crc32_check.sv =====
// Packet deframer with CRC-32 check.
// in_i carries one packet byte per item plus an is_final flag on the last
// byte; out_o returns exactly one item per input byte: the byte itself, its
// region tag (header, payload, out-of-band) and, on the final byte, the
// verdict (verdict_valid high, status set). Bytes must arrive in packet order.
// The APB port sets the expected start marker, version and ident; write it
// only while no packet is in flight. pready is tied high.
// Flow: an accepted item waits in the input register, moves into the result
// register once that register is free, and leaves out_o when the receiver is
// ready. Throughput: one byte per cycle while the receiver is ready; the
// byte-wide CRC update, header field compare and length add all sit between
// the input and result registers.
// Receiver stall: the result register holds its item; in_i.ready drops in the
// same cycle when the input register is full, else after it takes one more byte.
// Reset: both registers empty, byte count zero, both CRCs at all ones, the
// configuration registers at zero. No clearing pass is needed.
`default_nettype none
module packet_deframer_crc32_check (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  pdc_in_if.sink                           in_i,
  pdc_out_if.source                        out_o,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [pdc_pkg::PADDR_W-1:0] paddr,
  input  wire logic [31:0]                 pwdata,
  output logic      [31:0]                 prdata,
  output logic                             pready
);

  pdc_pkg::pdc_cfg_t    cfg;
  pdc_pkg::pdc_item_t   in_item_q;
  pdc_pkg::pdc_result_t res, out_res_q;
  logic                 in_valid_q, out_valid_q;
  logic                 out_free, advance, in_take;

  pdc_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Result register free when empty or being drained this cycle
  assign out_free   = !out_valid_q || out_o.ready;
  assign advance    = in_valid_q && out_free;
  assign in_i.ready = !in_valid_q || advance;
  assign in_take    = in_i.valid && in_i.ready;

  pdc_parser u_parser (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (advance),
    .item_i    (in_item_q),
    .cfg_i     (cfg),
    .res_o     (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_i.ready) begin
        in_valid_q <= in_i.valid;
      end
      if (out_free) begin
        out_valid_q <= in_valid_q;
      end
    end
  end

  // Payload registers: load on accept, hold otherwise
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_item_q.in_byte  <= in_i.in_byte;
      in_item_q.is_final <= in_i.is_final;
    end
    if (advance) begin
      out_res_q <= res;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.out_byte      = out_res_q.out_byte;
  assign out_o.region        = out_res_q.region;
  assign out_o.verdict_valid = out_res_q.verdict_valid;
  assign out_o.status        = out_res_q.status;

  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !out_free |=> in_valid_q && $stable(in_item_q))
    else $error("input register lost a waiting item");

  a_no_verdict_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_res_q.verdict_valid |-> out_res_q.status == pdc_pkg::ST_OK)
    else $error("status set on a non-final byte");

  a_move_fills_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_valid_q && out_res_q == $past(res))
    else $error("result register missed an item");

endmodule
`default_nettype wire
